// ----- sv/lu_linear_system_solver_assert.svh -----
// assertion macros for the solver rtl
`ifndef LU_LINEAR_SYSTEM_SOLVER_ASSERT_SVH
`define LU_LINEAR_SYSTEM_SOLVER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LUS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lu solver: same-cycle check failed");
`define LUS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lu solver: next-cycle check failed");
`else
`define LUS_ASSERT_IMP(name, ante, cons)
`define LUS_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ----- sv/lus_pkg.sv -----
`default_nettype none
package lus_pkg;

    localparam int MAX_UNKNOWNS_DEF = 8;
    localparam int MAX_RHS_DEF      = 4;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int FRAC_BITS        = 16;

    localparam int IN_W       = 32;
    localparam int OUT_W      = 32;
    localparam int ROW_IDX_W  = 3;
    localparam int COL_IDX_W  = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RHS  = 1'b1;

    localparam logic [3:0] SIZE_RST = 4'd2;
    localparam logic [2:0] RHS_RST  = 3'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } lus_div_stat_t;

endpackage
`default_nettype wire

// ----- sv/lus_ram.sv -----
`default_nettype none
module lus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/lus_mul.sv -----
`default_nettype none
module lus_mul #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] p
);
    import lus_pkg::*;

    localparam int MW = 2 * W + 1 - FRAC_BITS;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]   ua, ub;
    logic [2*W-1:0] prod_reg;
    logic           neg_reg;
    logic [2*W:0]   rl;
    logic [MW-1:0]  mag;
    logic           over_n;
    logic           big_p;

    assign ua = a[W-1] ? (~a + 1'b1) : a;
    assign ub = b[W-1] ? (~b + 1'b1) : b;

    // stage one: magnitude product
    always_ff @(posedge aclk) begin
        prod_reg <= ua * ub;
        neg_reg  <= a[W-1] ^ b[W-1];
    end

    // stage two: round half away from zero, then saturate
    assign rl     = {1'b0, prod_reg} + (2*W+1)'(1 << (FRAC_BITS - 1));
    assign mag    = rl[2*W:FRAC_BITS];
    assign big_p  = |mag[MW-1:W-1];
    assign over_n = (|mag[MW-1:W]) | (mag[W-1] & (|mag[W-2:0]));

    always_ff @(posedge aclk) begin
        if (neg_reg) begin
            p <= over_n ? VMIN : (~mag[W-1:0] + 1'b1);
        end else begin
            p <= big_p ? VMAX : mag[W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- sv/lus_div.sv -----
`default_nettype none
module lus_div #(
    parameter int W = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [W-1:0]          a,
    input  wire logic [W-1:0]          b,
    output logic      [W-1:0]          q,
    output lus_pkg::lus_div_stat_t     stat
);
    import lus_pkg::*;

    localparam int NB  = W + FRAC_BITS;
    localparam int QCW = $clog2(NB + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } dstate_t;

    dstate_t        state_reg, state_next;
    logic [QCW-1:0] cnt_reg;
    logic [NB-1:0]  num_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   ub_reg;
    logic           neg_reg;
    logic           done_reg;
    logic [W-1:0]   ua, ub;
    logic [W:0]     sh;
    logic           ge;
    logic [W:0]     sub;
    logic           rnd;
    logic [NB:0]    q1;
    logic           big_p, over_n;
    logic [W-1:0]   qsat;

    assign ua = a[W-1] ? (~a + 1'b1) : a;
    assign ub = b[W-1] ? (~b + 1'b1) : b;

    // one quotient bit per cycle
    assign sh  = {rem_reg, num_reg[NB-1]};
    assign ge  = sh >= {1'b0, ub_reg};
    assign sub = sh - {1'b0, ub_reg};

    assign rnd    = {rem_reg, 1'b0} >= {1'b0, ub_reg};
    assign q1     = {1'b0, num_reg} + (NB+1)'(rnd);
    assign big_p  = |q1[NB:W-1];
    assign over_n = (|q1[NB:W]) | (q1[W-1] & (|q1[W-2:0]));
    assign qsat   = neg_reg ? (over_n ? VMIN : (~q1[W-1:0] + 1'b1))
                            : (big_p ? VMAX : q1[W-1:0]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE: begin
                if (start && (ub != '0)) begin
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                if (cnt_reg == QCW'(1)) begin
                    state_next = D_FIN;
                end
            end
            D_FIN: begin
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_FIN) || ((state_reg == D_IDLE) && start && (ub == '0));
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    num_reg <= {ua, FRAC_BITS'(0)};
                    rem_reg <= '0;
                    ub_reg  <= ub;
                    neg_reg <= a[W-1] ^ b[W-1];
                    cnt_reg <= QCW'(NB);
                    // zero divisor saturates with the dividend's sign
                    if (ub == '0) begin
                        q <= a[W-1] ? VMIN : VMAX;
                    end
                end
            end
            D_RUN: begin
                rem_reg <= ge ? sub[W-1:0] : sh[W-1:0];
                num_reg <= {num_reg[NB-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            D_FIN: begin
                q <= qsat;
            end
            default: begin
            end
        endcase
    end

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- sv/lu_linear_system_solver.sv -----
// LU linear system solver
//
// s_ channel: augmented matrix, row-major, one signed Q16.16 element per beat
// (n coefficients then r right-hand sides per row). s_tready is high only while
// loading; after the last element the block eliminates and substitutes with one
// shared divider and one two-stage multiplier, reading and writing the working
// matrix through a single RAM. A row update takes one division, then reads,
// multiplies and writes back each column from the pivot column to the last.
// m_ channel: solution elements column by column, unknowns ascending; tlast marks
// the last one. A singular system gives a single beat with tuser set and zero
// data. A stalled receiver holds the sequencer at the output register. cfg_we
// writes a register and restarts loading; write only when idle.
// Reset (aresetn low, synchronous) restores n = 2, r = 1 and an empty load; the
// matrix RAM is not cleared.
`default_nettype none
`include "lu_linear_system_solver_assert.svh"
module lu_linear_system_solver #(
    parameter int MAX_UNKNOWNS = lus_pkg::MAX_UNKNOWNS_DEF,
    parameter int MAX_RHS      = lus_pkg::MAX_RHS_DEF,
    parameter int VALUE_WIDTH  = lus_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [lus_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [lus_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lus_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] element_value
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [31:0] solution_value, [34:32] row_index, [36:35] column_index, zero pad
    output logic      [lus_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                  m_tuser,  // [0] singular
    output logic                                  m_tlast
);
    import lus_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int STRIDE = MAX_UNKNOWNS + MAX_RHS;
    localparam int DEPTH  = MAX_UNKNOWNS * STRIDE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(STRIDE + 1);
    localparam int EW     = (W > IN_W) ? W : IN_W;
    localparam int EO     = (W > OUT_W) ? W : OUT_W;
    localparam int PAD    = M_TDATA_W - OUT_W - ROW_IDX_W - COL_IDX_W;
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [EW-1:0] IN_HI = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] IN_LO = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [EO-1:0] OUT_HI = {{(EO-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EO-1:0] OUT_LO = {{(EO-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef enum logic [27:0] {
        S_LOAD     = 28'h0000001,
        S_PIV_RD   = 28'h0000002,
        S_PIV_CHK  = 28'h0000004,
        S_SRCH_RD  = 28'h0000008,
        S_SRCH_CHK = 28'h0000010,
        S_SWP_RDA  = 28'h0000020,
        S_SWP_RDB  = 28'h0000040,
        S_SWP_WA   = 28'h0000080,
        S_SWP_WB   = 28'h0000100,
        S_ROW_RD   = 28'h0000200,
        S_ROW_CHK  = 28'h0000400,
        S_ROW_DIVW = 28'h0000800,
        S_UPD_RDK  = 28'h0001000,
        S_UPD_RDI  = 28'h0002000,
        S_UPD_MUL  = 28'h0004000,
        S_UPD_WR   = 28'h0008000,
        S_BS_RD    = 28'h0010000,
        S_BS_LD    = 28'h0020000,
        S_BS_J     = 28'h0040000,
        S_BS_M1    = 28'h0080000,
        S_BS_M2    = 28'h0100000,
        S_BS_M3    = 28'h0200000,
        S_BS_M4    = 28'h0400000,
        S_BS_DIVST = 28'h0800000,
        S_BS_DIVW  = 28'h1000000,
        S_OUT_RD   = 28'h2000000,
        S_OUT_PUT  = 28'h4000000,
        S_OUT_SING = 28'h8000000
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        addr_of = AW'(int'(r) * STRIDE + int'(c));
    endfunction

    function automatic logic [W-1:0] sub_sat(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] d;
        d = {a[W-1], a} - {b[W-1], b};
        if (d[W] != d[W-1]) begin
            sub_sat = d[W] ? VMIN : VMAX;
        end else begin
            sub_sat = d[W-1:0];
        end
    endfunction

    state_t        state_reg, state_next;
    logic [3:0]    size_reg;
    logic [2:0]    rhs_reg;
    logic [CW-1:0] k_reg, k_next, i_reg, i_next, j_reg, j_next, c_reg, c_next;
    logic [W-1:0]  piv_reg, piv_next, m_reg, m_next, hold_reg, hold_next, s_reg, s_next;
    logic [CW-1:0] n_eff, r_eff, w_eff, n_m1, w_m1, nc;

    logic          m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     sol_reg, sol_next;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic [COL_IDX_W-1:0] col_reg, col_next;
    logic          sing_reg, sing_next, last_reg, last_next;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, rdata;

    logic [W-1:0]  mul_p;
    logic          div_start;
    logic [W-1:0]  div_a, div_b, div_q;
    lus_div_stat_t div_st;

    logic              in_acc;
    logic signed [EW-1:0] in_ext;
    logic [W-1:0]      in_val;
    logic signed [EO-1:0] out_ext;
    logic [OUT_W-1:0]  out_val;

    // effective sizes, out-of-range settings clamped
    always_comb begin
        if (size_reg == '0) begin
            n_eff = ONE;
        end else if (int'(size_reg) > MAX_UNKNOWNS) begin
            n_eff = CW'(MAX_UNKNOWNS);
        end else begin
            n_eff = CW'(size_reg);
        end
        if (rhs_reg == '0) begin
            r_eff = ONE;
        end else if (int'(rhs_reg) > MAX_RHS) begin
            r_eff = CW'(MAX_RHS);
        end else begin
            r_eff = CW'(rhs_reg);
        end
    end

    assign w_eff = n_eff + r_eff;
    assign n_m1  = n_eff - ONE;
    assign w_m1  = w_eff - ONE;
    assign nc    = n_eff + c_reg;

    assign in_acc = s_tvalid && s_tready;
    assign in_ext = EW'(signed'(s_tdata[IN_W-1:0]));
    assign in_val = (in_ext > IN_HI) ? VMAX : ((in_ext < IN_LO) ? VMIN : in_ext[W-1:0]);
    assign out_ext = EO'(signed'(rdata));
    assign out_val = (out_ext > OUT_HI) ? {1'b0, {(OUT_W-1){1'b1}}}
                   : ((out_ext < OUT_LO) ? {1'b1, {(OUT_W-1){1'b0}}} : out_ext[OUT_W-1:0]);

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        case (state_reg)
            S_PIV_RD, S_PIV_CHK:                         ram_raddr = addr_of(k_reg, k_reg);
            S_SRCH_RD, S_SRCH_CHK, S_ROW_RD, S_ROW_CHK:  ram_raddr = addr_of(i_reg, k_reg);
            S_SWP_RDA, S_UPD_RDK:                        ram_raddr = addr_of(k_reg, j_reg);
            S_SWP_RDB, S_UPD_RDI, S_BS_M1:               ram_raddr = addr_of(i_reg, j_reg);
            S_BS_J: begin
                ram_raddr = (j_reg < n_eff) ? addr_of(j_reg, nc) : addr_of(i_reg, i_reg);
            end
            default:                                     ram_raddr = addr_of(i_reg, nc);
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_of(i_reg, j_reg);
        ram_wdata = rdata;
        case (state_reg)
            S_LOAD: begin
                ram_we    = in_acc;
                ram_wdata = in_val;
            end
            S_SWP_WA: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(k_reg, j_reg);
            end
            S_SWP_WB: begin
                ram_we    = 1'b1;
                ram_wdata = hold_reg;
            end
            S_UPD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = sub_sat(hold_reg, mul_p);
            end
            S_BS_DIVW: begin
                ram_we    = div_st.done;
                ram_waddr = addr_of(i_reg, nc);
                ram_wdata = div_q;
            end
            default: begin
            end
        endcase
    end

    assign div_start = ((state_reg == S_ROW_CHK) && (rdata != '0)) || (state_reg == S_BS_DIVST);
    assign div_a     = (state_reg == S_BS_DIVST) ? s_reg : rdata;
    assign div_b     = (state_reg == S_BS_DIVST) ? rdata : piv_reg;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        c_next       = c_reg;
        piv_next     = piv_reg;
        m_next       = m_reg;
        hold_next    = hold_reg;
        s_next       = s_reg;
        m_valid_next = m_valid_reg && !m_tready;
        sol_next     = sol_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        sing_next    = sing_reg;
        last_next    = last_reg;
        case (state_reg)
            S_LOAD: begin
                if (in_acc) begin
                    if (j_reg == w_m1) begin
                        j_next = '0;
                        if (i_reg == n_m1) begin
                            i_next     = '0;
                            k_next     = '0;
                            state_next = S_PIV_RD;
                        end else begin
                            i_next = i_reg + ONE;
                        end
                    end else begin
                        j_next = j_reg + ONE;
                    end
                end
                if (cfg_we) begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            S_PIV_RD: state_next = S_PIV_CHK;
            S_PIV_CHK: begin
                i_next = k_reg + ONE;
                if (rdata != '0) begin
                    piv_next   = rdata;
                    state_next = S_ROW_RD;
                end else begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                state_next = (i_reg >= n_eff) ? S_OUT_SING : S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (rdata != '0) begin
                    j_next     = '0;
                    state_next = S_SWP_RDA;
                end else begin
                    i_next     = i_reg + ONE;
                    state_next = S_SRCH_RD;
                end
            end
            S_SWP_RDA: state_next = S_SWP_RDB;
            S_SWP_RDB: begin
                hold_next  = rdata;
                state_next = S_SWP_WA;
            end
            S_SWP_WA: state_next = S_SWP_WB;
            S_SWP_WB: begin
                if (j_reg == w_m1) begin
                    state_next = S_PIV_RD;
                end else begin
                    j_next     = j_reg + ONE;
                    state_next = S_SWP_RDA;
                end
            end
            S_ROW_RD: begin
                if (i_reg >= n_eff) begin
                    if (k_reg == n_m1) begin
                        c_next     = '0;
                        i_next     = n_m1;
                        state_next = S_BS_RD;
                    end else begin
                        k_next     = k_reg + ONE;
                        state_next = S_PIV_RD;
                    end
                end else begin
                    state_next = S_ROW_CHK;
                end
            end
            S_ROW_CHK: begin
                // zero entry: row already clear in this column
                if (rdata == '0) begin
                    i_next     = i_reg + ONE;
                    state_next = S_ROW_RD;
                end else begin
                    state_next = S_ROW_DIVW;
                end
            end
            S_ROW_DIVW: begin
                if (div_st.done) begin
                    m_next     = div_q;
                    j_next     = k_reg;
                    state_next = S_UPD_RDK;
                end
            end
            S_UPD_RDK: state_next = S_UPD_RDI;
            S_UPD_RDI: state_next = S_UPD_MUL;
            S_UPD_MUL: begin
                hold_next  = rdata;
                state_next = S_UPD_WR;
            end
            S_UPD_WR: begin
                if (j_reg == w_m1) begin
                    i_next     = i_reg + ONE;
                    state_next = S_ROW_RD;
                end else begin
                    j_next     = j_reg + ONE;
                    state_next = S_UPD_RDK;
                end
            end
            S_BS_RD: state_next = S_BS_LD;
            S_BS_LD: begin
                s_next     = rdata;
                j_next     = i_reg + ONE;
                state_next = S_BS_J;
            end
            S_BS_J: begin
                state_next = (j_reg < n_eff) ? S_BS_M1 : S_BS_DIVST;
            end
            S_BS_M1: begin
                m_next     = rdata;
                state_next = S_BS_M2;
            end
            S_BS_M2: state_next = S_BS_M3;
            S_BS_M3: state_next = S_BS_M4;
            S_BS_M4: begin
                s_next     = sub_sat(s_reg, mul_p);
                j_next     = j_reg + ONE;
                state_next = S_BS_J;
            end
            S_BS_DIVST: state_next = S_BS_DIVW;
            S_BS_DIVW: begin
                if (div_st.done) begin
                    if (i_reg == '0) begin
                        if (c_reg == r_eff - ONE) begin
                            c_next     = '0;
                            state_next = S_OUT_RD;
                        end else begin
                            c_next     = c_reg + ONE;
                            i_next     = n_m1;
                            state_next = S_BS_RD;
                        end
                    end else begin
                        i_next     = i_reg - ONE;
                        state_next = S_BS_RD;
                    end
                end
            end
            S_OUT_RD: state_next = S_OUT_PUT;
            S_OUT_PUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    sol_next     = out_val;
                    row_next     = ROW_IDX_W'(i_reg);
                    col_next     = COL_IDX_W'(c_reg);
                    sing_next    = 1'b0;
                    last_next    = (i_reg == n_m1) && (c_reg == r_eff - ONE);
                    if ((i_reg == n_m1) && (c_reg == r_eff - ONE)) begin
                        i_next     = '0;
                        j_next     = '0;
                        c_next     = '0;
                        state_next = S_LOAD;
                    end else if (i_reg == n_m1) begin
                        i_next     = '0;
                        c_next     = c_reg + ONE;
                        state_next = S_OUT_RD;
                    end else begin
                        i_next     = i_reg + ONE;
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_OUT_SING: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    sol_next     = '0;
                    row_next     = '0;
                    col_next     = '0;
                    sing_next    = 1'b1;
                    last_next    = 1'b1;
                    i_next       = '0;
                    j_next       = '0;
                    state_next   = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            size_reg    <= SIZE_RST;
            rhs_reg     <= RHS_RST;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            c_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            c_reg       <= c_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SIZE: size_reg <= cfg_wdata[3:0];
                    CFG_RHS:  rhs_reg  <= cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        piv_reg  <= piv_next;
        m_reg    <= m_next;
        hold_reg <= hold_next;
        s_reg    <= s_next;
        sol_reg  <= sol_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        sing_reg <= sing_next;
        last_reg <= last_next;
    end

    lus_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mat (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // operand a is the held multiplier, b the word just read
    lus_mul #(
        .W (W)
    ) u_mul (
        .aclk (aclk),
        .a    (m_reg),
        .b    (rdata),
        .p    (mul_p)
    );

    lus_div #(
        .W (W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (div_a),
        .b       (div_b),
        .q       (div_q),
        .stat    (div_st)
    );

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, col_reg, row_reg, sol_reg};
    assign m_tuser  = sing_reg;
    assign m_tlast  = last_reg;

    `LUS_ASSERT_IMP(a_load_div_idle, s_tvalid && s_tready, !div_st.busy)
    `LUS_ASSERT_IMP(a_sing_beat, m_tvalid && m_tuser, m_tdata == '0 && m_tlast)
    `LUS_ASSERT_IMP(a_div_done_wait, div_st.done, state_reg == S_ROW_DIVW || state_reg == S_BS_DIVW)
    `LUS_ASSERT_NXT(a_out_load, state_reg == S_OUT_PUT && out_free, m_tvalid)

endmodule
`default_nettype wire
